// File: design/ttpt_pkg.sv
// Shared types and constants of the timed travel position tracker.
// Used by ttpt_div and timed_travel_position_tracker_unit; no dependencies.

package ttpt_pkg;

   localparam int POS_W            = 20;
   localparam int EXT_W            = 16;
   localparam int TIME_W           = 32;
   localparam int PCT_W            = 7;
   localparam int DIR_W            = 2;
   localparam int STOP_W           = 21;
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 20;
   localparam int POS_BITS_DEFAULT = 20;

   // Shared divider sizing: a 27 bit dividend covers 20 bit x 7 bit products,
   // and seven quotient bits cover a percent of travel.
   localparam int DIV_W     = 27;
   localparam int QUO_W     = 7;
   localparam int CNT_W     = 5;
   localparam int PCT_STEPS = 7;

   // Division by one hundred as a reciprocal multiplication: floor(x / 100)
   // equals (x * RECIP_100) >> RECIP_SHIFT for every x below 2^30.
   localparam int RECIP_W     = 28;
   localparam int RECIP_SHIFT = 34;
   localparam logic [RECIP_W-1:0] RECIP_100 = 28'd171798692;

   localparam logic [PCT_W-1:0] HUNDRED = 7'd100;

   localparam logic signed [DIR_W-1:0] DIR_UP   = -2'sd1;
   localparam logic signed [DIR_W-1:0] DIR_IDLE = 2'sd0;
   localparam logic signed [DIR_W-1:0] DIR_DOWN = 2'sd1;

   typedef enum logic [1:0] {
      KIND_TICK     = 2'd0,
      KIND_MOVE     = 2'd1,
      KIND_STOP     = 2'd2,
      KIND_OVERRIDE = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FULL_TRAVEL   = 1'b0,
      REG_END_EXTENSION = 1'b1
   } csr_reg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PCT_GO,
      S_PCT_WAIT,
      S_POS,
      S_PLAN_GO,
      S_PLAN_WAIT,
      S_MOVE,
      S_OVR_GO,
      S_OVR_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [TIME_W-1:0] now_ms;
      logic [PCT_W-1:0]  target_percent;
   } req_payload_type;

   typedef struct packed {
      logic signed [DIR_W-1:0] motion_dir;
      logic [PCT_W-1:0]        position_pct;
      logic [POS_W-1:0]        position_ms;
      logic                    up_relay_on;
      logic                    down_relay_on;
      logic                    save_position;
   } rsp_payload_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
      logic [CNT_W-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_stat_type;

endpackage

// File: design/ttpt_div.sv
// Shared restoring divider of the position tracker: one compare and subtract
// per cycle. Depends on ttpt_pkg for the command and status structs.

module ttpt_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ttpt_pkg::div_cmd_type div_cmd,
   output ttpt_pkg::div_stat_type div_stat
);
   import ttpt_pkg::*;

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dreg_ff, dreg_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // The divisor arrives already shifted to the top quotient bit, so the
   // dividend must be below divisor * 2 to keep every quotient bit single.
   always_comb begin
      rem_in  = rem_ff;
      dreg_in = dreg_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_cmd.start) begin
         rem_in  = div_cmd.dividend;
         dreg_in = div_cmd.divisor;
         quo_in  = '0;
         cnt_in  = div_cmd.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dreg_ff) begin
            rem_in = rem_ff - dreg_ff;
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         dreg_in = dreg_ff >> 1;
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dreg_ff <= dreg_in;
      quo_ff  <= quo_in;
   end

   assign div_stat.done     = done_ff;
   assign div_stat.quotient = quo_ff;

endmodule

// File: design/timed_travel_position_tracker_unit.sv
// Top level of the timed travel position tracker: sequencer, motion state and
// channels. Depends on ttpt_pkg and the shared divider ttpt_div.

// Each item produces exactly one result item. The block takes one item at a
// time; the percent of travel comes from a single serial divider that
// resolves one quotient bit per cycle, and that divider sets the cost. The
// planned travel and the override position are scaled by one hundredth with
// a reciprocal multiplication, the product registered before it is scaled.
// A tick or stop runs a 7 bit percent division, an override only the
// scaling, and a move the percent, the planned travel, and the percent
// again. The percent division is skipped when the travel limit is zero or
// the position is at or beyond it. A finished result sits in an output
// register, and the next item is taken while it waits. Configuration
// writes are always ready.

module timed_travel_position_tracker_unit #(
   parameter int POS_BITS = ttpt_pkg::POS_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ttpt_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ttpt_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ttpt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ttpt_pkg::CSR_DATA_W-1:0]      csr_data
);
   import ttpt_pkg::*;

   // Largest position the travel limit may take.
   localparam logic [POS_W-1:0] POS_CAP = (POS_BITS >= POS_W) ? {POS_W{1'b1}} :
                                          POS_W'((64'd1 << POS_BITS) - 64'd1);

   state_type state_ff, state_in;

   logic [POS_W-1:0]        full_travel_ff;
   logic [EXT_W-1:0]        end_ext_ff;

   logic [1:0]              kind_ff, kind_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic [PCT_W-1:0]        tgt_ff, tgt_in;
   logic                    pass2_ff, pass2_in;
   logic                    save_ff, save_in;
   logic [DIV_W-1:0]        prod_ff, prod_in;

   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [POS_W-1:0]        start_pos_ff, start_pos_in;
   logic [TIME_W-1:0]       start_time_ff, start_time_in;
   logic [STOP_W-1:0]       stop_after_ff, stop_after_in;
   logic signed [DIR_W-1:0] dir_ff, dir_in;
   logic [PCT_W-1:0]        pct_ff, pct_in;
   logic                    up_ff, up_in;
   logic                    down_ff, down_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_payload_ff, rsp_payload_in;

   div_cmd_type             div_cmd;
   div_stat_type            div_stat;

   logic [POS_W-1:0]        lim;
   logic                    accept;
   logic                    lim_zero;
   logic                    pct_skip;
   logic                    rsp_free;
   logic                    delta_zero;
   logic                    delta_neg;
   logic [PCT_W-1:0]        mag;
   logic [TIME_W-1:0]       dur;
   logic [TIME_W:0]         sum_dn;
   logic [POS_W-1:0]        np_dn;
   logic [POS_W-1:0]        np_up0;
   logic [POS_W-1:0]        np_up;
   logic                    motion_end;
   logic                    tgt_end;
   logic [DIV_W+RECIP_W-1:0] prod_mul;
   logic [POS_W-1:0]        scaled;
   logic [STOP_W:0]         plan_sum;

   ttpt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_cmd  (div_cmd),
      .div_stat (div_stat)
   );

   assign lim        = (full_travel_ff > POS_CAP) ? POS_CAP : full_travel_ff;
   assign lim_zero   = (lim == '0);
   assign pct_skip   = lim_zero || (pos_ff >= lim);
   assign accept     = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign delta_zero = (tgt_ff == pct_ff);
   assign delta_neg  = (tgt_ff < pct_ff);
   assign mag        = delta_neg ? (pct_ff - tgt_ff) : (tgt_ff - pct_ff);
   assign tgt_end    = (tgt_ff == '0) || (tgt_ff == HUNDRED);

   // Dead reckoning from the motion start point, clamped to [0, limit].
   assign dur        = now_ff - start_time_ff;
   assign sum_dn     = (TIME_W + 1)'(start_pos_ff) + (TIME_W + 1)'(dur);
   assign np_dn      = (sum_dn > (TIME_W + 1)'(lim)) ? lim : sum_dn[POS_W-1:0];
   assign np_up0     = (TIME_W'(start_pos_ff) < dur) ? '0 :
                       (start_pos_ff - dur[POS_W-1:0]);
   assign np_up      = (np_up0 > lim) ? lim : np_up0;
   assign motion_end = (dur > TIME_W'(stop_after_ff)) || (kind_ff == KIND_STOP);

   // The registered product is at most one hundred times the limit, so the
   // scaled value always fits the position width.
   assign prod_mul   = (DIV_W + RECIP_W)'(prod_ff) * (DIV_W + RECIP_W)'(RECIP_100);
   assign scaled     = prod_mul[RECIP_SHIFT +: POS_W];
   assign plan_sum   = (STOP_W + 1)'(scaled) +
                       (tgt_end ? (STOP_W + 1)'(end_ext_ff) : '0);

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_travel_ff <= '0;
         end_ext_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FULL_TRAVEL:   full_travel_ff <= csr_data;
            REG_END_EXTENSION: end_ext_ff     <= csr_data[EXT_W-1:0];
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_payload.kind)
                  KIND_OVERRIDE: state_in = S_OVR_GO;
                  KIND_MOVE:     state_in = lim_zero ? S_DONE : S_PCT_GO;
                  default:       state_in = S_PCT_GO;
               endcase
            end
         end
         S_PCT_GO: begin
            if (pct_skip) begin
               state_in = pass2_ff ? S_DONE : S_POS;
            end else begin
               state_in = S_PCT_WAIT;
            end
         end
         S_PCT_WAIT: begin
            if (div_stat.done) begin
               state_in = pass2_ff ? S_DONE : S_POS;
            end
         end
         S_POS: begin
            if (kind_ff == KIND_MOVE) begin
               state_in = delta_zero ? S_MOVE : S_PLAN_GO;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PLAN_GO:   state_in = S_PLAN_WAIT;
         S_PLAN_WAIT: state_in = S_MOVE;
         S_MOVE:      state_in = S_PCT_GO;
         S_OVR_GO:    state_in = S_OVR_WAIT;
         S_OVR_WAIT:  state_in = S_DONE;
         S_DONE:      if (rsp_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Handshake and divider commands.
   always_comb begin
      req_ready        = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = '0;
      div_cmd.divisor  = '0;
      div_cmd.steps    = '0;
      unique case (state_ff)
         S_IDLE: req_ready = 1'b1;
         S_PCT_GO: begin
            div_cmd.start    = !pct_skip;
            div_cmd.dividend = DIV_W'(pos_ff) * DIV_W'(HUNDRED);
            div_cmd.divisor  = DIV_W'(lim) << (PCT_STEPS - 1);
            div_cmd.steps    = CNT_W'(PCT_STEPS);
         end
         default: ;
      endcase
   end

   // Item and motion state updates.
   always_comb begin
      kind_in        = kind_ff;
      now_in         = now_ff;
      tgt_in         = tgt_ff;
      pass2_in       = pass2_ff;
      save_in        = save_ff;
      prod_in        = prod_ff;
      pos_in         = pos_ff;
      start_pos_in   = start_pos_ff;
      start_time_in  = start_time_ff;
      stop_after_in  = stop_after_ff;
      dir_in         = dir_ff;
      pct_in         = pct_ff;
      up_in          = up_ff;
      down_in        = down_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in  = req_payload.kind;
               now_in   = req_payload.now_ms;
               tgt_in   = (req_payload.target_percent > HUNDRED) ? HUNDRED :
                          req_payload.target_percent;
               pass2_in = 1'b0;
               save_in  = 1'b0;
            end
         end
         S_PCT_GO: begin
            if (lim_zero) begin
               pct_in = '0;
            end else if (pos_ff >= lim) begin
               pct_in = HUNDRED;
            end
         end
         S_PCT_WAIT: begin
            if (div_stat.done) begin
               pct_in = div_stat.quotient[PCT_W-1:0];
            end
         end
         S_POS: begin
            if (dir_ff != DIR_IDLE) begin
               pos_in = (dir_ff == DIR_DOWN) ? np_dn : np_up;
               if (motion_end) begin
                  dir_in  = DIR_IDLE;
                  up_in   = 1'b0;
                  down_in = 1'b0;
                  save_in = 1'b1;
               end
            end
         end
         S_PLAN_GO: begin
            prod_in = DIV_W'(lim) * DIV_W'(mag);
         end
         S_PLAN_WAIT: begin
            stop_after_in = plan_sum[STOP_W-1:0];
         end
         S_MOVE: begin
            // A move against a running motion sets the new relay and leaves
            // the other one at its level.
            if (!delta_zero) begin
               start_time_in = now_ff;
               start_pos_in  = pos_ff;
               if (delta_neg) begin
                  up_in  = 1'b1;
                  dir_in = DIR_UP;
               end else begin
                  down_in = 1'b1;
                  dir_in  = DIR_DOWN;
               end
            end
            if ((!delta_zero || (dir_ff != DIR_IDLE)) && (pos_ff > lim)) begin
               pos_in = lim;
            end
            pass2_in = 1'b1;
         end
         S_OVR_GO: begin
            prod_in = DIV_W'(lim) * DIV_W'(tgt_ff);
         end
         S_OVR_WAIT: begin
            pos_in = scaled;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.motion_dir    = dir_ff;
               rsp_payload_in.position_pct  = pct_ff;
               rsp_payload_in.position_ms   = pos_ff;
               rsp_payload_in.up_relay_on   = up_ff;
               rsp_payload_in.down_relay_on = down_ff;
               rsp_payload_in.save_position = save_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         pos_ff        <= '0;
         start_pos_ff  <= '0;
         start_time_ff <= '0;
         stop_after_ff <= '0;
         dir_ff        <= DIR_IDLE;
         pct_ff        <= '0;
         up_ff         <= 1'b0;
         down_ff       <= 1'b0;
         pass2_ff      <= 1'b0;
         save_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pos_ff        <= pos_in;
         start_pos_ff  <= start_pos_in;
         start_time_ff <= start_time_in;
         stop_after_ff <= stop_after_in;
         dir_ff        <= dir_in;
         pct_ff        <= pct_in;
         up_ff         <= up_in;
         down_ff       <= down_in;
         pass2_ff      <= pass2_in;
         save_ff       <= save_in;
      end
      kind_ff        <= kind_in;
      now_ff         <= now_in;
      tgt_ff         <= tgt_in;
      prod_ff        <= prod_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: tb/timed_travel_position_tracker_unit_test.sv
// Self-checking testbench for timed_travel_position_tracker_unit.
// Holds its own position estimator to predict every result item; needs only
// ttpt_pkg and the RTL of the block.
`timescale 1ns / 100ps

module timed_travel_position_tracker_unit_test;
   import ttpt_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 60;
   localparam int ITEMS_PER_SETTING = 160;
   localparam int MAX_PRINTED = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int send_gap_pct = 25;
   int rsp_stall_pct = 45;
   int mismatch_count = 0;
   int idle_cycles = 0;
   logic [TIME_W-1:0] clock_ms = '0;
   logic [PCT_W-1:0] last_target = '0;

   // Estimator copy: configuration and motion state as the block holds them.
   logic [POS_W-1:0] cfg_full_travel = '0;
   logic [EXT_W-1:0] cfg_end_ext = '0;
   logic [POS_W-1:0] est_pos = '0;
   logic [POS_W-1:0] est_start_pos = '0;
   logic [TIME_W-1:0] est_start_time = '0;
   logic [STOP_W-1:0] est_stop_after = '0;
   logic signed [DIR_W-1:0] est_dir = DIR_IDLE;
   logic [PCT_W-1:0] est_pct = '0;
   logic est_up = 1'b0;
   logic est_down = 1'b0;

   rsp_payload_type pending_estimates[$];

   timed_travel_position_tracker_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   function automatic longint travel_limit();
      longint pos_max;
      pos_max = (longint'(1) << POS_BITS_DEFAULT) - 1;
      return (longint'(cfg_full_travel) > pos_max) ? pos_max : longint'(cfg_full_travel);
   endfunction

   // Refreshes the percent from the position held so far, then moves the
   // position along the running motion. Returns 1 when the motion ends.
   function automatic bit advance_estimate(input logic [TIME_W-1:0] now, input bit halt);
      longint lim;
      longint scaled;
      longint np;
      logic [TIME_W-1:0] elapsed;
      lim = travel_limit();
      if (lim == 0) begin
         est_pct = '0;
      end else begin
         scaled = longint'(est_pos) * 100 / lim;
         est_pct = (scaled > 100) ? HUNDRED : 7'(scaled);
      end
      if (est_dir == DIR_IDLE) return 1'b0;
      elapsed = now - est_start_time;
      np = longint'(est_start_pos);
      if (est_dir == DIR_DOWN) np = np + longint'(elapsed);
      else np = np - longint'(elapsed);
      if (np < 0) np = 0;
      if (np > lim) np = lim;
      est_pos = 20'(np);
      if (elapsed > est_stop_after || halt) begin
         est_dir = DIR_IDLE;
         est_up = 1'b0;
         est_down = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_payload_type predict_estimate(input req_payload_type item);
      logic [PCT_W-1:0] tgt;
      bit saved;
      longint lim;
      longint plan;
      longint np;
      int delta;
      int mag;
      rsp_payload_type r;
      saved = 1'b0;
      tgt = (item.target_percent > HUNDRED) ? HUNDRED : item.target_percent;
      case (kind_type'(item.kind))
         KIND_TICK: begin
            saved = advance_estimate(item.now_ms, 1'b0);
         end
         KIND_MOVE: begin
            lim = travel_limit();
            if (lim != 0) begin
               saved = advance_estimate(item.now_ms, 1'b0);
               delta = int'(tgt) - int'(est_pct);
               if (delta != 0) begin
                  mag = (delta < 0) ? -delta : delta;
                  plan = lim * mag / 100;
                  if (tgt == 0 || tgt == HUNDRED) plan = plan + longint'(cfg_end_ext);
                  est_start_time = item.now_ms;
                  est_start_pos = est_pos;
                  est_stop_after = 21'(plan);
               end
               // A reversal sets the new relay and leaves the other one alone.
               if (delta < 0) begin
                  est_up = 1'b1;
                  est_dir = DIR_UP;
               end else if (delta > 0) begin
                  est_down = 1'b1;
                  est_dir = DIR_DOWN;
               end
               if (advance_estimate(item.now_ms, 1'b0)) saved = 1'b1;
            end
         end
         KIND_STOP: begin
            saved = advance_estimate(item.now_ms, 1'b1);
         end
         default: begin
            lim = travel_limit();
            np = lim * longint'(tgt) / 100;
            if (np > lim) np = lim;
            est_pos = 20'(np);
         end
      endcase
      r.motion_dir = est_dir;
      r.position_pct = est_pct;
      r.position_ms = est_pos;
      r.up_relay_on = est_up;
      r.down_relay_on = est_down;
      r.save_position = saved;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("%0t mismatch: %s", $time, what);
   endtask

   task automatic check_estimate(input rsp_payload_type got);
      rsp_payload_type want;
      if (pending_estimates.size() == 0) begin
         report_mismatch("result item arrived with no estimate waiting");
         return;
      end
      want = pending_estimates.pop_front();
      if (got.motion_dir !== want.motion_dir)
         report_mismatch($sformatf("motion_dir got %0d expected %0d",
                                   got.motion_dir, want.motion_dir));
      if (got.position_pct !== want.position_pct)
         report_mismatch($sformatf("position_pct got %0d expected %0d",
                                   got.position_pct, want.position_pct));
      if (got.position_ms !== want.position_ms)
         report_mismatch($sformatf("position_ms got %0d expected %0d",
                                   got.position_ms, want.position_ms));
      if (got.up_relay_on !== want.up_relay_on)
         report_mismatch($sformatf("up_relay_on got %0b expected %0b",
                                   got.up_relay_on, want.up_relay_on));
      if (got.down_relay_on !== want.down_relay_on)
         report_mismatch($sformatf("down_relay_on got %0b expected %0b",
                                   got.down_relay_on, want.down_relay_on));
      if (got.save_position !== want.save_position)
         report_mismatch($sformatf("save_position got %0b expected %0b",
                                   got.save_position, want.save_position));
   endtask

   // Everything is sampled at the edge, before the block's registers update.
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (rsp_valid && rsp_ready) begin
            check_estimate(rsp_payload);
            idle_cycles = 0;
         end
         if (csr_valid && csr_ready) begin
            if (csr_reg_type'(csr_index) == REG_FULL_TRAVEL) cfg_full_travel = csr_data;
            else cfg_end_ext = csr_data[EXT_W-1:0];
            idle_cycles = 0;
         end
         if (req_valid && req_ready) begin
            pending_estimates.push_back(predict_estimate(req_payload));
            idle_cycles = 0;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Valid is left high after acceptance so back-to-back items need no gap.
   task automatic send_item(input kind_type kind, input int unsigned elapsed_ms,
                            input logic [PCT_W-1:0] target);
      req_payload_type item;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      clock_ms = clock_ms + elapsed_ms;
      item.kind = kind;
      item.now_ms = clock_ms;
      item.target_percent = target;
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // The extra edge lets the monitor record an item accepted at the last one.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_estimates.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type which, input logic [CSR_DATA_W-1:0] value);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(input logic [POS_W-1:0] full_ms, input logic [EXT_W-1:0] ext_ms);
      write_reg(REG_FULL_TRAVEL, full_ms);
      write_reg(REG_END_EXTENSION, CSR_DATA_W'(ext_ms));
   endtask

   // Out of reset the travel is zero, so every command leaves the position at 0.
   task automatic test_disabled_travel();
      send_item(KIND_TICK, 0, 7'd0);
      send_item(KIND_MOVE, 5, 7'd50);
      send_item(KIND_OVERRIDE, 3, 7'd127);
      send_item(KIND_STOP, 2, 7'd0);
   endtask

   task automatic test_directed_motion();
      apply_setting(20'd1000, 16'd250);
      send_item(KIND_OVERRIDE, 0, 7'd127);
      send_item(KIND_TICK, 1, 7'd0);
      send_item(KIND_MOVE, 1, 7'd100);
      // This motion runs across the wrap of the millisecond counter.
      clock_ms = 32'hFFFF_FF00;
      send_item(KIND_MOVE, 0, 7'd0);
      send_item(KIND_TICK, 300, 7'd0);
      send_item(KIND_MOVE, 0, 7'd80);
      send_item(KIND_OVERRIDE, 40, 7'd10);
      send_item(KIND_TICK, 30, 7'd0);
      send_item(KIND_STOP, 10, 7'd0);
      send_item(KIND_STOP, 10, 7'd0);
      send_item(KIND_TICK, 10, 7'd0);
      send_item(KIND_MOVE, 5, 7'd127);
      send_item(KIND_TICK, 5000, 7'd0);
      send_item(KIND_OVERRIDE, 1, 7'd0);
      send_item(KIND_MOVE, 1, 7'd0);
   endtask

   task automatic test_travel_extremes();
      apply_setting(20'hFFFFF, 16'hFFFF);
      send_item(KIND_MOVE, 7, 7'd100);
      send_item(KIND_TICK, 2000000, 7'd0);
      send_item(KIND_OVERRIDE, 3, 7'd55);
      send_item(KIND_MOVE, 3, 7'd0);
      send_item(KIND_STOP, 12345, 7'd0);
   endtask

   // Mostly ticks that follow the motions started by moves, mixed with
   // stops, overrides, odd targets and jumps of the timestamp.
   task automatic test_random_motion(input int items_per_setting);
      logic [POS_W-1:0] full_ms;
      logic [EXT_W-1:0] ext_ms;
      int unsigned span;
      int unsigned step;
      int r;
      kind_type kind;
      logic [PCT_W-1:0] target;
      for (int setting = 0; setting < 4; setting++) begin
         case (setting)
            0: begin
               full_ms = POS_W'($urandom_range(1, 300));
               ext_ms = EXT_W'($urandom_range(0, 400));
            end
            1: begin
               full_ms = POS_W'($urandom_range(1000, 60000));
               ext_ms = EXT_W'($urandom_range(0, 65535));
            end
            2: begin
               case ($urandom_range(0, 3))
                  0: full_ms = '0;
                  1: full_ms = 20'd1;
                  default: full_ms = 20'hFFFFF;
               endcase
               ext_ms = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
            end
            default: begin
               full_ms = POS_W'($urandom_range(100, 5000));
               ext_ms = '0;
            end
         endcase
         apply_setting(full_ms, ext_ms);
         span = (int'(full_ms) + int'(ext_ms)) / 6 + 2;
         for (int n = 0; n < items_per_setting; n++) begin
            step = $urandom_range(0, span);
            if ($urandom_range(0, 99) < 4) begin
               clock_ms = $urandom();
               step = 0;
            end
            r = $urandom_range(0, 99);
            if (r < 55) kind = KIND_TICK;
            else if (r < 80) kind = KIND_MOVE;
            else if (r < 88) kind = KIND_STOP;
            else kind = KIND_OVERRIDE;
            r = $urandom_range(0, 99);
            if (r < 25) target = '0;
            else if (r < 50) target = HUNDRED;
            else if (r < 58) target = PCT_W'($urandom_range(101, 127));
            else if (r < 68) target = last_target;
            else target = PCT_W'($urandom_range(0, 100));
            if (kind == KIND_MOVE) last_target = target;
            send_item(kind, step, target);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_disabled_travel();
      test_directed_motion();
      test_travel_extremes();
      test_random_motion(ITEMS_PER_SETTING);
      send_gap_pct = 45;
      rsp_stall_pct = 25;
      test_random_motion(ITEMS_PER_SETTING);
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      test_random_motion(ITEMS_PER_SETTING);
      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_estimates.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_estimates.size()));
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
